### src/wms_pkg.sv
// wms_pkg: shared types, sizes and helpers of the window median select block
// used by every module under src except wms_ram; no dependencies

package wms_pkg;

    localparam int MAX_RADIUS  = 3;
    localparam int STORE_SIDE  = 2 * MAX_RADIUS + 1;
    localparam int STORE_DEPTH = STORE_SIDE * STORE_SIDE;
    localparam int DATA_W      = 8;
    localparam int RADIUS_W    = 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int BIT_W       = $clog2(DATA_W);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

    typedef logic [RADIUS_W-1:0] radius_t;
    typedef logic [DATA_W-1:0]   sample_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [BIT_W-1:0]    bit_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_EMIT
    } state_t;

    // sequencer to select unit
    typedef struct packed {
        logic     clear;
        logic     data_vld;
        logic     data_last;
        bit_idx_t bit_idx;
        count_t   rank_k;
    } sel_ctl_t;

    // number of samples in a window of radius r, radius saturated to the store
    function automatic count_t win_size(input radius_t r);
        count_t rs;
        count_t side;
        rs   = (CNT_W'(r) > CNT_W'(MAX_RADIUS)) ? CNT_W'(MAX_RADIUS) : CNT_W'(r);
        side = CNT_W'(2 * rs + 1);
        return CNT_W'(side * side);
    endfunction

endpackage

### src/wms_ram.sv
// wms_ram: generic single write, single read memory with registered read data
// no package dependencies

module wms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 49
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/wms_select_unit.sv
// wms_select_unit: shared compare and count unit, builds the median bit by bit
// depends on wms_pkg

module wms_select_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  wms_pkg::sel_ctl_t  ctl,
    input  wms_pkg::sample_t   rd_data,
    output wms_pkg::sample_t   median
);
    import wms_pkg::*;

    sample_t ans_reg, ans_next;
    count_t  cnt_reg, cnt_next;
    sample_t trial;
    logic    lt;
    count_t  cnt_sum;

    // candidate with the current bit set; count samples below it
    assign trial   = ans_reg | (DATA_W'(1) << ctl.bit_idx);
    assign lt      = (rd_data < trial);
    assign cnt_sum = cnt_reg + CNT_W'(lt);

    always_comb
    begin
        ans_next = ans_reg;
        cnt_next = cnt_reg;
        if (ctl.clear)
        begin
            ans_next = '0;
            cnt_next = '0;
        end
        else if (ctl.data_vld)
        begin
            if (ctl.data_last)
            begin
                // keep the bit while no more than k samples lie below
                if (cnt_sum <= ctl.rank_k)
                begin
                    ans_next = trial;
                end
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ans_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            ans_reg <= ans_next;
            cnt_reg <= cnt_next;
        end
    end

    assign median = ans_reg;

endmodule

### src/wms_ctrl.sv
// wms_ctrl: sequencer for sample intake and the per-bit scans of the store
// depends on wms_pkg

module wms_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  wms_pkg::radius_t   radius,
    input  logic               out_free,
    output logic               in_ready,
    output logic               out_load,
    output logic               wr_en,
    output wms_pkg::addr_t     wr_addr,
    output wms_pkg::addr_t     rd_addr,
    output wms_pkg::sel_ctl_t  sel_ctl
);
    import wms_pkg::*;

    state_t   state_reg, state_next;
    count_t   seen_reg, seen_next;
    addr_t    addr_reg, addr_next;
    bit_idx_t bit_reg, bit_next;
    count_t   size_reg, size_next;
    logic     rd_pend_reg, rd_pend_next;

    count_t   cur_size;
    count_t   seen_inc;
    logic     win_done;
    logic     addr_end;

    assign cur_size = win_size(radius);
    assign wr_addr  = (seen_reg >= CNT_W'(STORE_DEPTH)) ? '0 : seen_reg[ADDR_W-1:0];
    assign seen_inc = CNT_W'(wr_addr) + CNT_W'(1);
    assign win_done = in_accept && (seen_inc >= cur_size);
    assign addr_end = (CNT_W'(addr_reg) == size_reg - CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (win_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_end)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = (bit_reg == '0) ? ST_EMIT : ST_SCAN;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath counters
    always_comb
    begin
        in_ready     = 1'b0;
        out_load     = 1'b0;
        wr_en        = 1'b0;
        seen_next    = seen_reg;
        addr_next    = addr_reg;
        bit_next     = bit_reg;
        size_next    = size_reg;
        rd_pend_next = 1'b0;
        sel_ctl.clear     = 1'b0;
        sel_ctl.data_vld  = rd_pend_reg;
        sel_ctl.data_last = 1'b0;
        sel_ctl.bit_idx   = bit_reg;
        sel_ctl.rank_k    = (size_reg - CNT_W'(1)) >> 1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                wr_en    = in_accept;
                if (in_accept)
                begin
                    seen_next = win_done ? '0 : seen_inc;
                end
                if (win_done)
                begin
                    sel_ctl.clear = 1'b1;
                    size_next     = cur_size;
                    addr_next     = '0;
                    bit_next      = BIT_W'(DATA_W - 1);
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = 1'b1;
                addr_next    = addr_end ? '0 : addr_reg + ADDR_W'(1);
            end
            ST_LAST:
            begin
                sel_ctl.data_last = 1'b1;
                if (bit_reg != '0)
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign rd_addr = addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seen_reg    <= '0;
            addr_reg    <= '0;
            bit_reg     <= '0;
            size_reg    <= CNT_W'(1);
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seen_reg    <= seen_next;
            addr_reg    <= addr_next;
            bit_reg     <= bit_next;
            size_reg    <= size_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

endmodule

### src/window_median_select.sv
// window_median_select: top level, median of one square window of samples
// depends on wms_pkg, wms_ram, wms_ctrl and wms_select_unit

// Samples of a (2r+1) x (2r+1) window arrive one beat at a time on the slave
// stream, r being the radius register (0..3, reset 1). Each sample is
// written to a 49-entry store as it is accepted. The beat that completes the
// window starts the median search, and the block drops s_axis_tready until
// the search is done and the median is loaded into the output register: a
// single comparator and counter walks the n stored samples once for each of
// the 8 result bits, from the top bit down, reading one sample a cycle from
// the store's single read port. The median then sits in the output register
// until the master side takes it, while new samples of the next window are
// already accepted. Samples compare as unsigned. Write the radius only between
// windows or while the block is idle; a radius written mid-window makes the
// next sample close the window once the count reaches the new size, and the
// median is then taken over the first samples of the store.

module window_median_select (
    input  logic                      clk,
    input  logic                      rst_n,
    // config
    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_wr_data,    // window_radius
    // sample stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // sample
    // median stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata    // median
);
    import wms_pkg::*;

    radius_t  radius_reg;
    logic     m_valid_reg, m_valid_next;
    sample_t  m_data_reg, m_data_next;

    logic     in_accept;
    logic     out_free;
    logic     in_ready;
    logic     out_load;
    logic     wr_en;
    addr_t    wr_addr;
    addr_t    rd_addr;
    sample_t  rd_data;
    sample_t  median;
    sel_ctl_t sel_ctl;

    assign in_accept     = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;
    // output register is free when empty or being drained this cycle
    assign out_free      = !m_valid_reg || m_axis_tready;

    // radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    // window sample store
    wms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // intake and scan sequencer
    wms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .radius    (radius_reg),
        .out_free  (out_free),
        .in_ready  (in_ready),
        .out_load  (out_load),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .sel_ctl   (sel_ctl)
    );

    // bitwise rank search
    wms_select_unit u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sel_ctl),
        .rd_data (rd_data),
        .median  (median)
    );

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = median;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### src/wms_checker.sv
// wms_checker: port-level checks of window_median_select, bound to the top level
// depends on wms_pkg

module wms_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata
);
    import wms_pkg::*;

    radius_t radius_reg;
    logic    s_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;

    // shadow of the radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    // a held median does not change under backpressure
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("median changed while stalled");

    // a one-sample window starts the search at once
    a_r0_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat && !cfg_wr_en && radius_reg == '0 |=> !s_axis_tready)
        else $error("radius 0 sample did not start a search");

    // a new median appears only as the search ends and intake reopens
    a_out_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && $past(!s_axis_tready))
        else $error("median appeared outside the end of a search");

    // nothing is offered during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("median valid during reset");

endmodule

bind window_median_select wms_checker u_wms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
